FILE: design/ubi_arx_pkg.sv
// shared types, constants and round helpers for the ubi arx compression block
// depends on nothing; used by the round cell and the top level
`timescale 1ns / 1ps
`default_nettype none

package ubi_arx_pkg;

  // cipher geometry
  localparam int MAX_ROUNDS     = 64;
  localparam int DEFAULT_ROUNDS = 46;
  localparam int CNT_W          = $clog2(MAX_ROUNDS + 1);
  localparam int RC_W           = 7;
  localparam int REQ_W          = 9;

  // rotation amounts
  localparam int ROT_X0  = 6;
  localparam int ROT_M9  = 9;
  localparam int ROT_X3  = 15;
  localparam int ROT_M14 = 14;
  localparam int ROT_T7  = 7;
  localparam int ROT_T17 = 17;
  localparam int ROT_K3  = 3;
  localparam int ROT_K5  = 5;

  typedef logic [CNT_W-1:0] cnt_t;

  // state carried by one word through the round chain
  typedef struct packed {
    logic [3:0][31:0] x;
    logic [63:0]      key0;
    logic [63:0]      key1;
    logic [63:0]      tw0;
    logic [63:0]      tw1;
    logic [63:0]      blk_low;
    logic [63:0]      blk_high;
    logic [63:0]      pos;
    cnt_t             total;
  } stage_t;

  function automatic logic [31:0] rol32(input logic [31:0] v, input int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  function automatic logic [63:0] rol64(input logic [63:0] v, input int s);
    return (v << s) | (v >> (64 - s));
  endfunction

  // register value to effective round count, zero selects the default, saturated
  function automatic cnt_t eff_rounds(input logic [RC_W-1:0] rc);
    logic [REQ_W-1:0] req;
    req = (rc == '0) ? REQ_W'(DEFAULT_ROUNDS) : REQ_W'(rc);
    if (req > REQ_W'(MAX_ROUNDS)) begin
      req = REQ_W'(MAX_ROUNDS);
    end
    return CNT_W'(req);
  endfunction

endpackage

`default_nettype wire

FILE: design/ubi_arx_in_if.sv
// input channel of the ubi arx compression block: valid/ready plus block fields
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

interface ubi_arx_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] chain_low;
  logic [63:0] chain_high;
  logic [63:0] position;
  logic [4:0]  bytes_added;
  logic [63:0] tweak_high;
  logic [63:0] block_low;
  logic [63:0] block_high;

  modport source (
    output valid, chain_low, chain_high, position, bytes_added, tweak_high,
           block_low, block_high,
    input  ready
  );

  modport sink (
    input  valid, chain_low, chain_high, position, bytes_added, tweak_high,
           block_low, block_high,
    output ready
  );
endinterface

`default_nettype wire

FILE: design/ubi_arx_out_if.sv
// result channel of the ubi arx compression block: valid/ready plus result fields
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

interface ubi_arx_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] new_chain_low;
  logic [63:0] new_chain_high;
  logic [63:0] new_position;

  modport source (
    output valid, new_chain_low, new_chain_high, new_position,
    input  ready
  );

  modport sink (
    input  valid, new_chain_low, new_chain_high, new_position,
    output ready
  );
endinterface

`default_nettype wire

FILE: design/ubi_arx_cell.sv
// one round cell of the chain: applies round round_idx to the word it holds
// depends on ubi_arx_pkg
`timescale 1ns / 1ps
`default_nettype none

module ubi_arx_cell (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                adv,
  input  wire ubi_arx_pkg::cnt_t   round_idx,
  input  wire logic                in_valid,
  input  wire ubi_arx_pkg::stage_t in_data,
  output logic                     out_valid,
  output ubi_arx_pkg::stage_t      out_data
);

  logic                valid_r;
  ubi_arx_pkg::stage_t data_r;
  ubi_arx_pkg::stage_t data_nxt;

  logic        active;
  logic        last;
  logic [31:0] sk_lo;
  logic [31:0] sk_hi;
  logic [31:0] mix;
  logic [31:0] sum_b;
  logic [31:0] sum_c;
  logic [63:0] nt1;
  logic [63:0] nk1;

  // round function and key/tweak schedule step
  always_comb begin
    active   = round_idx < in_data.total;
    last     = (ubi_arx_pkg::cnt_t'(round_idx + 1'b1)) >= in_data.total;
    sk_lo    = in_data.key0[31:0];
    sk_hi    = in_data.key0[63:32];
    mix      = in_data.x[1] ^ in_data.x[2];
    sum_b    = ubi_arx_pkg::rol32(in_data.x[0], ubi_arx_pkg::ROT_X0)
             + ubi_arx_pkg::rol32(mix, ubi_arx_pkg::ROT_M9);
    sum_c    = ubi_arx_pkg::rol32(in_data.x[3], ubi_arx_pkg::ROT_X3)
             + ubi_arx_pkg::rol32(mix, ubi_arx_pkg::ROT_M14);
    nt1      = in_data.tw0 ^ ubi_arx_pkg::rol64(in_data.tw1, ubi_arx_pkg::ROT_T7)
             ^ ubi_arx_pkg::rol64(in_data.tw1, ubi_arx_pkg::ROT_T17);
    nk1      = in_data.key0 ^ ubi_arx_pkg::rol64(in_data.key1, ubi_arx_pkg::ROT_K3)
             ^ ubi_arx_pkg::rol64(in_data.key1, ubi_arx_pkg::ROT_K5);
    data_nxt = in_data;
    if (active && !last) begin
      data_nxt.x[0] = in_data.x[1] ^ sk_lo;
      data_nxt.x[1] = sum_b;
      data_nxt.x[2] = sum_c;
      data_nxt.x[3] = in_data.x[2] ^ sk_hi;
      data_nxt.tw0  = in_data.tw1;
      data_nxt.key0 = in_data.key1;
      data_nxt.tw1  = nt1;
      data_nxt.key1 = nk1 ^ nt1 ^ 64'(round_idx);
    end else if (active) begin
      // final round mixes in place
      data_nxt.x[0] = sum_b;
      data_nxt.x[1] = in_data.x[1] ^ sk_lo;
      data_nxt.x[2] = in_data.x[2] ^ sk_hi;
      data_nxt.x[3] = sum_c;
    end
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

FILE: design/ubi_arx_block_compression_top.sv
// Skein-style UBI compression of one 16-byte block over a 128-bit ARX cipher.
// A chain of MAX_ROUNDS (64) round cells, one register stage per round, takes a
// new word every cycle unless a result waits untaken on the output; words using
// fewer rounds pass the unused cells unchanged. The whole chain advances
// together, so a result left waiting on the output holds every stage and
// in_ch.ready falls until it is taken. round_count is sampled when a word is
// accepted; zero selects 46 rounds and values above 64 saturate.
// depends on ubi_arx_pkg, ubi_arx_in_if, ubi_arx_out_if and ubi_arx_cell
`timescale 1ns / 1ps
`default_nettype none

module ubi_arx_block_compression_top (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  ubi_arx_in_if.sink                            in_ch,
  ubi_arx_out_if.source                         out_ch,
  input  wire logic                             cfg_we,
  input  wire logic [ubi_arx_pkg::RC_W-1:0]     cfg_wdata
);

  logic [ubi_arx_pkg::RC_W-1:0] round_count_r;
  logic                         adv;
  ubi_arx_pkg::stage_t          head;

  logic                [ubi_arx_pkg::MAX_ROUNDS:0] chain_valid;
  ubi_arx_pkg::stage_t [ubi_arx_pkg::MAX_ROUNDS:0] chain_data;

  // round count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      round_count_r <= '0;
    end else if (cfg_we) begin
      round_count_r <= cfg_wdata;
    end
  end

  // chain moves whenever the output slot is free or being taken
  assign adv         = !chain_valid[ubi_arx_pkg::MAX_ROUNDS] || out_ch.ready;
  assign in_ch.ready = adv;

  // initial cipher state from the accepted word
  always_comb begin
    head.x[0]     = in_ch.block_low[31:0];
    head.x[1]     = in_ch.block_low[63:32];
    head.x[2]     = in_ch.block_high[31:0];
    head.x[3]     = in_ch.block_high[63:32];
    head.key0     = in_ch.chain_low;
    head.key1     = in_ch.chain_high;
    head.pos      = in_ch.position + 64'(in_ch.bytes_added);
    head.tw0      = head.pos;
    head.tw1      = in_ch.tweak_high;
    head.blk_low  = in_ch.block_low;
    head.blk_high = in_ch.block_high;
    head.total    = ubi_arx_pkg::eff_rounds(round_count_r);
  end

  assign chain_valid[0] = in_ch.valid;
  assign chain_data[0]  = head;

  // row of round cells
  for (genvar g = 0; g < ubi_arx_pkg::MAX_ROUNDS; g++) begin : g_cell
    ubi_arx_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .round_idx (ubi_arx_pkg::cnt_t'(g)),
      .in_valid  (chain_valid[g]),
      .in_data   (chain_data[g]),
      .out_valid (chain_valid[g+1]),
      .out_data  (chain_data[g+1])
    );
  end

  // feed-forward of the block and result word
  assign out_ch.valid          = chain_valid[ubi_arx_pkg::MAX_ROUNDS];
  assign out_ch.new_chain_low  = {chain_data[ubi_arx_pkg::MAX_ROUNDS].x[1],
                                  chain_data[ubi_arx_pkg::MAX_ROUNDS].x[0]}
                               ^ chain_data[ubi_arx_pkg::MAX_ROUNDS].blk_low;
  assign out_ch.new_chain_high = {chain_data[ubi_arx_pkg::MAX_ROUNDS].x[3],
                                  chain_data[ubi_arx_pkg::MAX_ROUNDS].x[2]}
                               ^ chain_data[ubi_arx_pkg::MAX_ROUNDS].blk_high;
  assign out_ch.new_position   = chain_data[ubi_arx_pkg::MAX_ROUNDS].pos;

endmodule

`default_nettype wire
